// ===== hw/rtl/exadsr_pkg.sv =====
// ============================================================================
// exadsr_pkg
// Shared types and constants for the exponential ADSR envelope VCA.
// ============================================================================
package exadsr_pkg;

    // Fixed-point widths.
    localparam int LEVEL_W  = 31;
    localparam int BASE_W   = 32;
    localparam int SAMPLE_W = 24;
    localparam int STAGE_W  = 3;
    localparam int OUT_W    = 64;

    // Unity gain in Q1.30.
    localparam logic [LEVEL_W-1:0] ONE_Q30 = 31'h4000_0000;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Input opcodes.
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_RESET    = 2'd3
    } t_op;

    // Stage codes as they appear on the output word.
    localparam logic [STAGE_W-1:0] STAGE_IDLE    = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_DECAY   = 3'd2;
    localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_RELEASE = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ATTACK_COEFF  = 3'd0;
    localparam logic [2:0] CFG_ATTACK_BASE   = 3'd1;
    localparam logic [2:0] CFG_DECAY_COEFF   = 3'd2;
    localparam logic [2:0] CFG_DECAY_BASE    = 3'd3;
    localparam logic [2:0] CFG_RELEASE_COEFF = 3'd4;
    localparam logic [2:0] CFG_RELEASE_BASE  = 3'd5;
    localparam logic [2:0] CFG_SUSTAIN_LEVEL = 3'd6;

    // One decoded command word.
    typedef struct packed {
        t_op                        op;
        logic signed [SAMPLE_W-1:0] sample;
    } t_cmd;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Configuration write as seen by the back end.
    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_wr;

endpackage

// ===== hw/rtl/exadsr_front.sv =====
// ============================================================================
// exadsr_front
// Input side: accepts stream words, decodes the opcode and queues commands.
// ============================================================================
module exadsr_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [exadsr_pkg::SAMPLE_W-1:0]        i_s_tdata,
    input  logic [1:0]                             i_s_tuser,
    output exadsr_pkg::t_q_head                    o_head,
    input  logic                                   i_pop
);
    import exadsr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_cmd             w_cmd;
    logic             w_push;
    logic             w_pop;

    // Decode the incoming word into a command.
    always_comb begin
        w_cmd.op     = t_op'(i_s_tuser);
        w_cmd.sample = $signed(i_s_tdata);
    end

    assign o_s_tready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

    // Occupancy update.
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ===== hw/rtl/exadsr_back.sv =====
// ============================================================================
// exadsr_back
// Envelope engine: register file, level recurrence, sample scaling, output.
// ============================================================================
module exadsr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  exadsr_pkg::t_cfg_wr             i_cfg,
    input  exadsr_pkg::t_q_head             i_head,
    output logic                            o_pop,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [exadsr_pkg::OUT_W-1:0]    o_m_tdata
);
    import exadsr_pkg::*;

    typedef enum logic [2:0] {
        B_WAIT  = 3'b001,
        B_STEP  = 3'b010,
        B_SCALE = 3'b100
    } t_bstate;

    typedef enum logic [4:0] {
        ENV_IDLE    = 5'b00001,
        ENV_ATTACK  = 5'b00010,
        ENV_DECAY   = 5'b00100,
        ENV_SUSTAIN = 5'b01000,
        ENV_RELEASE = 5'b10000
    } t_env;

    localparam int PROD_W  = 2 * LEVEL_W;
    localparam int CAND_W  = BASE_W + 2;
    localparam int SCALE_W = SAMPLE_W + BASE_W;
    localparam logic signed [CAND_W-1:0] ONE_CAND = $signed({3'd0, ONE_Q30});

    function automatic logic [STAGE_W-1:0] env_code(input t_env env);
        logic [STAGE_W-1:0] code;
        unique case (env)
            ENV_IDLE:    code = STAGE_IDLE;
            ENV_ATTACK:  code = STAGE_ATTACK;
            ENV_DECAY:   code = STAGE_DECAY;
            ENV_SUSTAIN: code = STAGE_SUSTAIN;
            ENV_RELEASE: code = STAGE_RELEASE;
            default:     code = STAGE_IDLE;
        endcase
        return code;
    endfunction

    // Configuration registers.
    logic [LEVEL_W-1:0] r_attack_coeff;
    logic [BASE_W-1:0]  r_attack_base;
    logic [LEVEL_W-1:0] r_decay_coeff;
    logic [BASE_W-1:0]  r_decay_base;
    logic [LEVEL_W-1:0] r_release_coeff;
    logic [BASE_W-1:0]  r_release_base;
    logic [LEVEL_W-1:0] r_sustain_level;

    // Control and envelope state.
    t_bstate            r_state, n_state;
    t_env               r_env, n_env;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic               r_m_valid, n_m_valid;

    // Datapath registers.
    logic [PROD_W-1:0]          r_prod;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [OUT_W-1:0]           r_out;

    logic                       w_take_tick;
    logic                       w_load_out;
    logic [LEVEL_W-1:0]         w_coeff;
    logic [BASE_W-1:0]          w_base;
    logic [LEVEL_W-1:0]         w_floor;
    logic signed [CAND_W-1:0]   w_floor_c;
    logic signed [CAND_W-1:0]   w_cand;
    logic signed [SCALE_W-1:0]  w_scale;

    // Stage-dependent coefficient and base; idle and sustain never use them.
    always_comb begin
        unique case (r_env)
            ENV_ATTACK: begin
                w_coeff = r_attack_coeff;
                w_base  = r_attack_base;
            end
            ENV_DECAY: begin
                w_coeff = r_decay_coeff;
                w_base  = r_decay_base;
            end
            ENV_RELEASE: begin
                w_coeff = r_release_coeff;
                w_base  = r_release_base;
            end
            default: begin
                w_coeff = '0;
                w_base  = '0;
            end
        endcase
    end

    // Candidate level: floor(level * coeff / 2^30) + base, with headroom.
    assign w_cand = $signed({2'b00, r_prod[PROD_W-1:30]})
                  + $signed({{2{w_base[BASE_W-1]}}, w_base});

    // The decay floor is the sustain level capped at unity.
    assign w_floor   = (r_sustain_level > ONE_Q30) ? ONE_Q30 : r_sustain_level;
    assign w_floor_c = $signed({3'd0, w_floor});

    // Output product of the sample and the updated level.
    assign w_scale = $signed({{BASE_W{r_sample[SAMPLE_W-1]}}, r_sample})
                   * $signed({{(SCALE_W-LEVEL_W){1'b0}}, r_level});

    // Sequencer and envelope update.
    always_comb begin
        n_state     = r_state;
        n_env       = r_env;
        n_level     = r_level;
        o_pop       = 1'b0;
        w_take_tick = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            B_WAIT: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.cmd.op)
                        OP_TICK: begin
                            w_take_tick = 1'b1;
                            n_state     = B_STEP;
                        end
                        OP_NOTE_ON: begin
                            if (r_env == ENV_IDLE || r_env == ENV_RELEASE) begin
                                n_env = ENV_ATTACK;
                            end
                        end
                        OP_NOTE_OFF: begin
                            if (r_env != ENV_IDLE) begin
                                n_env = ENV_RELEASE;
                            end
                        end
                        OP_RESET: begin
                            n_env   = ENV_IDLE;
                            n_level = '0;
                        end
                        default: ;
                    endcase
                end
            end
            B_STEP: begin
                n_state = B_SCALE;
                unique case (r_env)
                    ENV_ATTACK: begin
                        if (w_cand >= ONE_CAND) begin
                            n_level = ONE_Q30;
                            n_env   = ENV_DECAY;
                        end else if (w_cand < $signed(CAND_W'(0))) begin
                            n_level = '0;
                        end else begin
                            n_level = w_cand[LEVEL_W-1:0];
                        end
                    end
                    ENV_DECAY: begin
                        if (w_cand <= w_floor_c) begin
                            n_level = w_floor;
                            n_env   = ENV_SUSTAIN;
                        end else if (w_cand > ONE_CAND) begin
                            n_level = ONE_Q30;
                        end else begin
                            n_level = w_cand[LEVEL_W-1:0];
                        end
                    end
                    ENV_RELEASE: begin
                        if (w_cand <= $signed(CAND_W'(0))) begin
                            n_level = '0;
                            n_env   = ENV_IDLE;
                        end else if (w_cand > ONE_CAND) begin
                            n_level = ONE_Q30;
                        end else begin
                            n_level = w_cand[LEVEL_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            B_SCALE: begin
                if (!r_m_valid || i_m_tready) begin
                    w_load_out = 1'b1;
                    n_state    = B_WAIT;
                end
            end
            default: n_state = B_WAIT;
        endcase
    end

    // Output valid: set on load, cleared when the word is taken.
    always_comb begin
        n_m_valid = r_m_valid;
        if (w_load_out) begin
            n_m_valid = 1'b1;
        end else if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= B_WAIT;
            r_env           <= ENV_IDLE;
            r_level         <= '0;
            r_m_valid       <= 1'b0;
            r_attack_coeff  <= '0;
            r_attack_base   <= '0;
            r_decay_coeff   <= '0;
            r_decay_base    <= '0;
            r_release_coeff <= '0;
            r_release_base  <= '0;
            r_sustain_level <= '0;
        end else begin
            r_state   <= n_state;
            r_env     <= n_env;
            r_level   <= n_level;
            r_m_valid <= n_m_valid;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_ATTACK_COEFF:  r_attack_coeff  <= i_cfg.data[LEVEL_W-1:0];
                    CFG_ATTACK_BASE:   r_attack_base   <= i_cfg.data;
                    CFG_DECAY_COEFF:   r_decay_coeff   <= i_cfg.data[LEVEL_W-1:0];
                    CFG_DECAY_BASE:    r_decay_base    <= i_cfg.data;
                    CFG_RELEASE_COEFF: r_release_coeff <= i_cfg.data[LEVEL_W-1:0];
                    CFG_RELEASE_BASE:  r_release_base  <= i_cfg.data;
                    CFG_SUSTAIN_LEVEL: r_sustain_level <= i_cfg.data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_take_tick) begin
            r_prod   <= {{LEVEL_W{1'b0}}, r_level} * {{LEVEL_W{1'b0}}, w_coeff};
            r_sample <= i_head.cmd.sample;
        end
        if (w_load_out) begin
            r_out <= {{(OUT_W-STAGE_W-LEVEL_W-SAMPLE_W){1'b0}}, env_code(r_env),
                      r_level, w_scale[SAMPLE_W+29:30]};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_out;

endmodule

// ===== hw/rtl/exponential_adsr_envelope_vca.sv =====
// ============================================================================
// exponential_adsr_envelope_vca
// Exponential ADSR amplitude envelope that scales a stream of audio samples.
// ============================================================================
//
//  channel   direction  signals                        word
//  --------  ---------  -----------------------------  ---------------------
//  s_axis    in         tvalid tready tdata tuser      opcode, sample_in
//  m_axis    out        tvalid tready tdata            sample_out, level, stage
//  cfg       in         i_cfg_valid o_cfg_ready        register index, data
//
// In the back end a tick goes through the product of level and stage
// coefficient, add/clamp of the new level, then the sample product into the
// output register once the previous output word is taken. Note on, note off and
// reset give no word. A two-word command queue parts the input from the engine,
// so input words are still taken while an output word waits, until it fills.
// Reset is synchronous and active low; it clears the queue, the envelope
// (idle, level zero), the output valid and all configuration registers.
// The configuration channel is always ready.
//
module exponential_adsr_envelope_vca (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [23:0] sample_out, [54:24] envelope_level,
                                        // [57:55] stage, [63:58] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import exadsr_pkg::*;

    t_q_head w_head;
    t_cfg_wr w_cfg;
    logic    w_pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cfg.valid = i_cfg_valid && o_cfg_ready;
        w_cfg.index = i_cfg_index;
        w_cfg.data  = i_cfg_data;
    end

    // Input side and command queue.
    exadsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // Envelope engine.
    exadsr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

    // The delivered level never exceeds unity.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[54:24] <= ONE_Q30))
        else $error("envelope level above unity");

    // The delivered stage is one of the five defined codes.
    a_stage_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[57:55] <= STAGE_RELEASE))
        else $error("undefined stage code");

    // An idle envelope always carries a zero level and a zero sample.
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[57:55] == STAGE_IDLE)
            |-> (m_axis_tdata[54:24] == '0 && m_axis_tdata[23:0] == '0))
        else $error("idle stage with nonzero level");

    // The pad bits of the output word stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:58] == '0))
        else $error("output pad bits not zero");

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the exponential ADSR envelope VCA. Opcode words go
// in on the input stream. A cycle-free predictor computes the envelope stage,
// the level and the scaled sample for every tick. Each output word is then
// compared field by field against the oldest predicted word. The bench runs
// a short directed walk through the stages and the clamps, then random note
// sequences under many register settings, with random idling on both sides
// and one long output stall.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import exadsr_pkg::*;

    localparam logic [31:0] UNITY_WORD  = 32'h4000_0000;
    localparam longint      UNITY_Q30   = 64'sd1073741824;
    localparam logic [2:0]  CFG_UNUSED  = 3'd7;
    localparam int          HOLD_CYCLES = 300;
    localparam int          SETTLE      = 12;

    // One predicted output word.
    typedef struct packed {
        logic signed [23:0] sample;
        logic [30:0]        level;
        logic [2:0]         stage;
    } t_vca_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;     // [23:0] sample_in
    logic [1:0]  s_axis_tuser  = '0;     // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // [23:0] sample_out, [54:24] envelope_level,
                                         // [57:55] stage, [63:58] zero
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;

    // Predictor state: register file, stage and level.
    logic [31:0] cfg_regs [0:6];
    logic [2:0]  env_stage = STAGE_IDLE;
    longint      env_level = 0;
    t_vca_word   vca_words_due [$];

    // Register values to be written by the next programming pass.
    logic [31:0] cfg_plan [0:6];

    int          n_errors     = 0;
    int          n_items      = 0;
    int          n_words      = 0;
    int          n_cfg_writes = 0;
    bit          tx_steady    = 1'b0;
    bit          rx_steady    = 1'b0;
    int unsigned hold_request = 0;

    exponential_adsr_envelope_vca dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Generous limit on the whole run.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // One level step: floor(level * coeff / 2^30) + signed base.
    function automatic longint next_level(input logic [2:0] coeff_idx,
                                          input logic [2:0] base_idx);
        longint coeff;
        longint base;
        coeff = cfg_regs[coeff_idx][30:0];
        base  = $signed(cfg_regs[base_idx]);
        return ((env_level * coeff) >>> 30) + base;
    endfunction

    function automatic longint clamp_level(input longint cand);
        if (cand < 0)
            return 0;
        if (cand > UNITY_Q30)
            return UNITY_Q30;
        return cand;
    endfunction

    // Apply one accepted command word and queue the word a tick produces.
    function automatic void apply_command(input t_op op, input logic [23:0] smp);
        longint    cand;
        longint    lvl_floor;
        longint    scaled;
        t_vca_word w;
        case (op)
            OP_NOTE_ON: begin
                if (env_stage == STAGE_IDLE || env_stage == STAGE_RELEASE)
                    env_stage = STAGE_ATTACK;
            end
            OP_NOTE_OFF: begin
                if (env_stage != STAGE_IDLE)
                    env_stage = STAGE_RELEASE;
            end
            OP_RESET: begin
                env_stage = STAGE_IDLE;
                env_level = 0;
            end
            default: begin
                case (env_stage)
                    STAGE_ATTACK: begin
                        cand = next_level(CFG_ATTACK_COEFF, CFG_ATTACK_BASE);
                        if (cand >= UNITY_Q30) begin
                            cand      = UNITY_Q30;
                            env_stage = STAGE_DECAY;
                        end
                        env_level = clamp_level(cand);
                    end
                    STAGE_DECAY: begin
                        cand      = next_level(CFG_DECAY_COEFF, CFG_DECAY_BASE);
                        lvl_floor = cfg_regs[CFG_SUSTAIN_LEVEL][30:0];
                        if (lvl_floor > UNITY_Q30)
                            lvl_floor = UNITY_Q30;
                        if (cand <= lvl_floor) begin
                            cand      = lvl_floor;
                            env_stage = STAGE_SUSTAIN;
                        end
                        env_level = clamp_level(cand);
                    end
                    STAGE_RELEASE: begin
                        cand = next_level(CFG_RELEASE_COEFF, CFG_RELEASE_BASE);
                        if (cand <= 0) begin
                            cand      = 0;
                            env_stage = STAGE_IDLE;
                        end
                        env_level = clamp_level(cand);
                    end
                    default: ;
                endcase
                // Sample times level, floored: bits 53..30 of the exact product.
                scaled   = longint'($signed(smp)) * env_level;
                w.sample = scaled[53:30];
                w.level  = env_level[30:0];
                w.stage  = env_stage;
                vca_words_due.push_back(w);
            end
        endcase
    endfunction

    // Follow register writes and accepted input words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            env_stage = STAGE_IDLE;
            env_level = 0;
            foreach (cfg_regs[i])
                cfg_regs[i] = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_cfg_writes++;
                if (i_cfg_index <= CFG_SUSTAIN_LEVEL)
                    cfg_regs[i_cfg_index] = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n_items++;
                apply_command(t_op'(s_axis_tuser), s_axis_tdata);
            end
        end
    end

    task automatic report_field(input string name, input longint want_v,
                                input longint got_v);
        if (want_v !== got_v) begin
            n_errors++;
            $display("%0t ns: %s mismatch: expected %0d, got %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    // Compare every output word with the oldest prediction.
    always @(posedge i_clk) begin
        t_vca_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_words++;
            if (vca_words_due.size() == 0) begin
                n_errors++;
                $display("%0t ns: unexpected word: expected none, got %h",
                         $time, m_axis_tdata);
            end else begin
                want = vca_words_due.pop_front();
                report_field("sample_out", want.sample, $signed(m_axis_tdata[23:0]));
                report_field("envelope_level", want.level, m_axis_tdata[54:24]);
                report_field("stage", want.stage, m_axis_tdata[57:55]);
                report_field("padding", 0, m_axis_tdata[63:58]);
            end
        end
    end

    // Output side: random stalls, steady stretches, and long hold-offs on request.
    always @(posedge i_clk) begin
        int unsigned hold_seen;
        int          hold_left;
        if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 22);
        end
    end

    // Offer one word and wait until it is taken, with an occasional gap first.
    task automatic send_word(input t_op op, input logic [23:0] smp);
        int gap;
        gap = 0;
        if (!tx_steady && $urandom_range(99) < 11)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write the planned values; now and then also poke the index past the list.
    task automatic program_regs();
        for (int i = CFG_ATTACK_COEFF; i <= CFG_SUSTAIN_LEVEL; i++)
            write_reg(3'(i), cfg_plan[i]);
        if ($urandom_range(3) == 0)
            write_reg(CFG_UNUSED, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every predicted word, then let the engine settle.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (vca_words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(15))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            default: return 24'($urandom);
        endcase
    endfunction

    // Mostly envelopes that move through every stage, sometimes anything at all.
    task automatic program_random_envelope();
        if ($urandom_range(99) < 20) begin
            foreach (cfg_plan[i])
                cfg_plan[i] = $urandom;
        end else begin
            cfg_plan[CFG_ATTACK_COEFF]  = $urandom_range(UNITY_WORD - (UNITY_WORD >> 2),
                                                         UNITY_WORD);
            cfg_plan[CFG_ATTACK_BASE]   = $urandom_range(32'h0100_0000, 32'h2000_0000);
            cfg_plan[CFG_DECAY_COEFF]   = $urandom_range(UNITY_WORD >> 1, UNITY_WORD);
            cfg_plan[CFG_DECAY_BASE]    = -$urandom_range(0, 32'h0800_0000);
            cfg_plan[CFG_RELEASE_COEFF] = $urandom_range(UNITY_WORD >> 1, UNITY_WORD);
            cfg_plan[CFG_RELEASE_BASE]  = -$urandom_range(32'h0010_0000, 32'h1000_0000);
            cfg_plan[CFG_SUSTAIN_LEVEL] = $urandom_range(0, UNITY_WORD);
        end
        program_regs();
    endtask

    // Walk one note through attack, decay, sustain and release by hand.
    task automatic test_directed_walk();
        cfg_plan[CFG_ATTACK_COEFF]  = UNITY_WORD;
        cfg_plan[CFG_ATTACK_BASE]   = 32'h2000_0000;
        cfg_plan[CFG_DECAY_COEFF]   = UNITY_WORD >> 1;
        cfg_plan[CFG_DECAY_BASE]    = 32'h0000_0000;
        cfg_plan[CFG_RELEASE_COEFF] = UNITY_WORD >> 1;
        cfg_plan[CFG_RELEASE_BASE]  = 32'hF800_0000;
        cfg_plan[CFG_SUSTAIN_LEVEL] = 32'h2000_0000;
        program_regs();
        send_word(OP_TICK, 24'h7F_FFFF);      // idle tick, level zero
        send_word(OP_NOTE_OFF, 24'h00_0000);  // note off while idle is ignored
        send_word(OP_NOTE_ON, 24'h00_0000);
        send_word(OP_TICK, 24'h7F_FFFF);
        send_word(OP_TICK, 24'h80_0000);      // attack reaches unity, on to decay
        send_word(OP_NOTE_ON, 24'h12_3456);   // legato: ignored in decay
        send_word(OP_TICK, 24'hFF_FFFF);      // decay lands on sustain
        send_word(OP_TICK, 24'h00_0000);      // sustain holds
        send_word(OP_NOTE_ON, 24'h55_5555);   // legato: ignored in sustain
        send_word(OP_NOTE_OFF, 24'hAA_AAAA);
        send_word(OP_TICK, 24'h40_0000);
        send_word(OP_NOTE_ON, 24'h00_0000);   // retrigger from release
        send_word(OP_TICK, 24'hC0_0000);
        send_word(OP_NOTE_OFF, 24'h00_0000);
        send_word(OP_TICK, 24'h7F_FFFF);
        send_word(OP_TICK, 24'h80_0000);      // release falls below zero, goes idle
        send_word(OP_TICK, 24'h00_0001);
        send_word(OP_NOTE_ON, 24'h00_0000);
        send_word(OP_RESET, 24'hFF_FFFF);     // reset in the middle of attack
        send_word(OP_TICK, 24'h7F_FFFF);
        drain_pipeline();
    endtask

    // Saturation at both ends with the widest register values.
    task automatic test_clamps();
        cfg_plan[CFG_ATTACK_COEFF]  = 32'hFFFF_FFFF;
        cfg_plan[CFG_ATTACK_BASE]   = 32'h7FFF_FFFF;
        cfg_plan[CFG_DECAY_COEFF]   = 32'hFFFF_FFFF;
        cfg_plan[CFG_DECAY_BASE]    = 32'h7FFF_FFFF;
        cfg_plan[CFG_RELEASE_COEFF] = 32'hFFFF_FFFF;
        cfg_plan[CFG_RELEASE_BASE]  = 32'h7FFF_FFFF;
        cfg_plan[CFG_SUSTAIN_LEVEL] = 32'hFFFF_FFFF;
        program_regs();
        send_word(OP_NOTE_ON, 24'h00_0000);
        send_word(OP_TICK, 24'h7F_FFFF);      // straight to unity
        send_word(OP_TICK, 24'h80_0000);      // decay saturates at unity
        send_word(OP_NOTE_OFF, 24'h00_0000);
        send_word(OP_TICK, 24'h7F_FFFF);      // release saturates at unity
        drain_pipeline();

        cfg_plan[CFG_ATTACK_COEFF]  = 32'h0000_0000;
        cfg_plan[CFG_ATTACK_BASE]   = 32'h8000_0000;
        cfg_plan[CFG_DECAY_COEFF]   = 32'h0000_0000;
        cfg_plan[CFG_DECAY_BASE]    = 32'h8000_0000;
        cfg_plan[CFG_RELEASE_COEFF] = 32'h0000_0000;
        cfg_plan[CFG_RELEASE_BASE]  = 32'h8000_0000;
        cfg_plan[CFG_SUSTAIN_LEVEL] = 32'h0000_0000;
        program_regs();
        send_word(OP_NOTE_ON, 24'h00_0000);   // release back to attack
        send_word(OP_TICK, 24'h80_0000);      // negative attack step stays at zero
        send_word(OP_NOTE_OFF, 24'h00_0000);
        send_word(OP_TICK, 24'h7F_FFFF);
        drain_pipeline();
    endtask

    // Random notes with random content, plus stray words of any opcode.
    task automatic test_random_envelopes(input int n_target);
        int sent;
        int n_ticks;
        sent = 0;
        while (sent < n_target) begin
            if ($urandom_range(99) < 85) begin
                send_word(OP_NOTE_ON, pick_sample());
                n_ticks = $urandom_range(1, 12);
                repeat (n_ticks) send_word(OP_TICK, pick_sample());
                sent += n_ticks + 2;
                send_word(OP_NOTE_OFF, pick_sample());
                n_ticks = $urandom_range(1, 10);
                repeat (n_ticks) send_word(OP_TICK, pick_sample());
                sent += n_ticks;
            end else begin
                send_word(t_op'($urandom_range(3)), pick_sample());
                sent++;
            end
        end
        drain_pipeline();
    endtask

    // Both sides at full rate for a while.
    task automatic test_full_rate();
        program_random_envelope();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        test_random_envelopes(200);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Output held off for a long stretch while ticks keep coming.
    task automatic test_back_pressure();
        program_random_envelope();
        tx_steady = 1'b1;
        send_word(OP_NOTE_ON, pick_sample());
        hold_request++;
        repeat (40) send_word(OP_TICK, pick_sample());
        tx_steady = 1'b0;
        drain_pipeline();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_walk();
        test_clamps();
        for (int p = 0; p < 8; p++) begin
            program_random_envelope();
            test_random_envelopes(170);
        end
        test_full_rate();
        test_back_pressure();

        if (vca_words_due.size() != 0)
            $display("%0t ns: %0d predicted words never arrived",
                     $time, vca_words_due.size());
        $display("Run covered %0d input words, %0d output words, %0d register writes,",
                 n_items, n_words, n_cfg_writes);
        $display("over all stages, legato, retrigger, reset, clamps and a long stall.");
        if (n_errors == 0 && vca_words_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
